### rtl/edup_pkg.sv
// Package for the edge-directed pixel upscaler: scale codes, the output block
// size and the default pixel width. No dependencies.
package edup_pkg;

  localparam int PIXEL_BITS_DEFAULT = 8;
  localparam int BLOCK_PIXELS       = 9;

  typedef logic [1:0] scale_t;

  localparam scale_t SCALE_2X    = 2'd2;
  localparam scale_t SCALE_3X    = 2'd3;
  localparam scale_t SCALE_RESET = SCALE_2X;

  // Number of columns held in the window saturates at two.
  typedef logic [1:0] col_count_t;
  localparam col_count_t WINDOW_FULL = 2'd2;

endpackage

### rtl/edup_rules.sv
// Corner rules and output block layout of the edge-directed upscaler.
// Depends on edup_pkg; purely combinational.
module edup_rules #(
  parameter int PIXEL_BITS = edup_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic [PIXEL_BITS-1:0]                               px_b,
  input  logic [PIXEL_BITS-1:0]                               px_d,
  input  logic [PIXEL_BITS-1:0]                               px_e,
  input  logic [PIXEL_BITS-1:0]                               px_f,
  input  logic [PIXEL_BITS-1:0]                               px_h,
  input  edup_pkg::scale_t                                    scale,
  output logic [edup_pkg::BLOCK_PIXELS-1:0][PIXEL_BITS-1:0]   blk
);
  import edup_pkg::*;

  logic [PIXEL_BITS-1:0] tl, tr, bl, br;

  always_comb begin
    tl = (px_d == px_b && px_b != px_f && px_d != px_h) ? px_d : px_e;
    tr = (px_b == px_f && px_b != px_d && px_f != px_h) ? px_f : px_e;
    bl = (px_d == px_h && px_d != px_b && px_h != px_f) ? px_d : px_e;
    br = (px_h == px_f && px_d != px_h && px_b != px_f) ? px_f : px_e;
  end

  // Entries are in row-major order: index = row * 3 + column.
  always_comb begin
    blk = '0;
    if (scale == SCALE_3X) begin
      for (int i = 0; i < BLOCK_PIXELS; i++) begin
        blk[i] = px_e;
      end
      blk[0] = tl;
      blk[2] = tr;
      blk[6] = bl;
      blk[8] = br;
    end else begin
      blk[0] = tl;
      blk[1] = tr;
      blk[3] = bl;
      blk[4] = br;
    end
  end

endmodule

### rtl/edge_directed_pixel_upscaler_unit.sv
// Top level of the edge-directed pixel upscaler (2x and 3x corner rules).
// Depends on edup_pkg and edup_rules.
//
// Usage
// The pixel channel (pix_valid / pix_ready) takes one word per source column:
// the pixels above, at and below the current row, plus row_start, which marks
// column -1 of a new row. A row is fed from column -1 to column width, with
// the caller supplying the border pixels. The block keeps the two previous
// columns as a sliding 3x3 window; from the third word of a row onwards each
// word yields one output block on the result channel (blk_valid / blk_ready).
// In 2x mode the block is out_0_0..out_1_1 and the other fields are zero; in
// 3x mode all nine fields are used. Scale codes other than 2 or 3 give no
// block, although the window still advances.
// A block appears on the result channel at the clock edge that accepts its
// source word. Throughput is one word per cycle while the receiver does not
// stall, set by the single result register; the corner logic sits between the
// window registers and that register.
// When the receiver stalls, the held block stays put and pix_ready stays low
// for as long as a block is held and blk_ready is low, whether or not the next
// word would yield a block. Reset empties the window and the result register
// and sets the scale factor to 2x. cfg_we writes the scale factor, and should
// only be used while the block is idle.
module edge_directed_pixel_upscaler_unit #(
  parameter int PIXEL_BITS = edup_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  edup_pkg::scale_t        cfg_wdata,
  input  logic                    pix_valid,
  output logic                    pix_ready,
  input  logic [PIXEL_BITS-1:0]   pixel_above,
  input  logic [PIXEL_BITS-1:0]   pixel_center,
  input  logic [PIXEL_BITS-1:0]   pixel_below,
  input  logic                    row_start,
  output logic                    blk_valid,
  input  logic                    blk_ready,
  output logic [PIXEL_BITS-1:0]   out_0_0,
  output logic [PIXEL_BITS-1:0]   out_0_1,
  output logic [PIXEL_BITS-1:0]   out_0_2,
  output logic [PIXEL_BITS-1:0]   out_1_0,
  output logic [PIXEL_BITS-1:0]   out_1_1,
  output logic [PIXEL_BITS-1:0]   out_1_2,
  output logic [PIXEL_BITS-1:0]   out_2_0,
  output logic [PIXEL_BITS-1:0]   out_2_1,
  output logic [PIXEL_BITS-1:0]   out_2_2
);
  import edup_pkg::*;

  // Window: index 0 above, 1 centre, 2 below.
  logic [2:0][PIXEL_BITS-1:0] left_column;
  logic [2:0][PIXEL_BITS-1:0] middle_column;
  col_count_t                 columns_seen;
  col_count_t                 seen_now;
  col_count_t                 columns_seen_next;
  scale_t                     scale_factor;

  logic [BLOCK_PIXELS-1:0][PIXEL_BITS-1:0] blk_calc;
  logic [BLOCK_PIXELS-1:0][PIXEL_BITS-1:0] blk_pix;

  logic accept;
  logic scale_ok;
  logic emit;

  // A word can enter whenever the result register is empty or being emptied.
  assign pix_ready = !blk_valid || blk_ready;
  assign accept    = pix_valid && pix_ready;

  // A row start discards whatever the window held before this word.
  assign seen_now = row_start ? '0 : columns_seen;
  assign scale_ok = (scale_factor == SCALE_2X) || (scale_factor == SCALE_3X);
  assign emit     = (seen_now == WINDOW_FULL) && scale_ok;
  assign columns_seen_next = (seen_now == WINDOW_FULL) ? WINDOW_FULL
                                                       : seen_now + col_count_t'(1);

  edup_rules #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_rules (
    .px_b  (middle_column[0]),
    .px_d  (left_column[1]),
    .px_e  (middle_column[1]),
    .px_f  (pixel_center),
    .px_h  (middle_column[2]),
    .scale (scale_factor),
    .blk   (blk_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_factor <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_column   <= '0;
      middle_column <= '0;
      columns_seen  <= '0;
    end else if (accept) begin
      left_column   <= middle_column;
      middle_column <= {pixel_below, pixel_center, pixel_above};
      columns_seen  <= columns_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (accept && emit) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      blk_pix <= blk_calc;
    end
  end

  assign out_0_0 = blk_pix[0];
  assign out_0_1 = blk_pix[1];
  assign out_0_2 = blk_pix[2];
  assign out_1_0 = blk_pix[3];
  assign out_1_1 = blk_pix[4];
  assign out_1_2 = blk_pix[5];
  assign out_2_0 = blk_pix[6];
  assign out_2_1 = blk_pix[7];
  assign out_2_2 = blk_pix[8];

  // The column count saturates at two and never reaches three.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    columns_seen != 2'd3)
    else $error("column count out of range");

  // A row-start word only fills the window.
  a_row_start_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && row_start) |-> !emit)
    else $error("row start word produced a block");

  // An emitting word always leaves a valid block behind it.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> blk_valid)
    else $error("block lost after emitting word");

  // A word taken without an emit never raises the result valid.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!blk_valid && !(accept && emit)) |=> !blk_valid)
    else $error("block appeared without a source word");

endmodule
